// File: rtl/flbcc_pkg.sv
`timescale 1ns / 1ps

package flbcc_pkg;

    // field widths
    localparam int PIX_W      = 8;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 7;
    localparam int INT_W      = 16;
    localparam int COEF_W     = 17;
    localparam int WGT_W      = 25;
    localparam int PROD_W     = 32;
    localparam int FRAC_W     = 8;
    localparam int IP_PROD_W  = 24;

    // channels and lut geometry
    localparam int CH_NUM      = 3;
    localparam int CH_W        = 2;
    localparam int LUT_ENTRIES = 257;
    localparam int LUT_AW      = $clog2(LUT_ENTRIES);
    localparam int LUT_DW      = 15;

    // matrix size
    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 128;

    // stream and register port widths
    localparam int IN_DATA_W  = 88;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NO_INTERP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NO_DITHER = 2'd2;

    // beat kinds
    localparam logic OP_PIXEL  = 1'b0;
    localparam logic OP_LUT_WR = 1'b1;

    // arithmetic constants
    localparam logic [COEF_W-1:0] COEF_ONE    = 17'h10000;
    localparam logic [8:0]        BLEND_SCALE = 9'd257;
    localparam logic [8:0]        FRAC_ONE    = 9'd256;
    localparam logic [INT_W-1:0]  DITHER_MASK = 16'hff00;
    localparam logic [INT_W-1:0]  FIRST_PIXEL = 16'hffff;

    typedef logic [PIX_W-1:0]  t_pix;
    typedef logic [INT_W-1:0]  t_int;
    typedef logic [LUT_DW-1:0] t_lut;
    typedef logic [FRAC_W-1:0] t_frac;

    // control that travels with each beat down the pipeline
    typedef struct packed {
        logic pix;      // pixel inside the matrix, gives a result
        logic wr;       // valid lut entry write
        logic first;    // pixel at column 0, row 0
    } t_ctl;

    typedef struct packed {
        logic [CH_W-1:0]   ch;
        logic [LUT_AW-1:0] idx;
        t_lut              val;
    } t_lut_wr;

endpackage

// File: rtl/frame_blend_lut_color_correct_unit.sv
`timescale 1ns / 1ps

// frame blend and lut color correction, one pixel beat per clock unless stalled
// slave stream: tuser is the beat kind (0 pixel, 1 lut entry write); a pixel
//   beat carries position and the previous and next keyframe rgb bytes, a
//   write beat carries channel, entry index and 15-bit entry value
// master stream: one beat of corrected 16-bit red, green, blue for every
//   pixel inside the matrix; lut writes and pixels outside give no beat
// register port: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 coefficient, 1 no interpolation, 2 no dithering); write only while idle
// path: a pixel accepted on the slave side passes the capture register, blend
//   multiply, sum, lut read, interpolation multiply, sum and mask and the
//   output register before its result beat shows on the master side
// throughput: one beat per cycle unless stalled; the six-stage pipeline and
//   the three two-read-port lut memories each take a new beat every cycle
// stall: a skid register behind the output register catches the beat in
//   flight; s_axis_tready drops while it is full and the pipeline holds
// reset: clears all valid bits and sets the coefficient to one (next frame
//   only); the lut contents are undefined until written
module frame_blend_lut_color_correct_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // slave side
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // column, row, prev_red, prev_green, prev_blue, next_red, next_green,
    // next_blue, lut_channel, lut_index, lut_value
    input  logic [flbcc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // operation
    input  logic [flbcc_pkg::IN_USER_W-1:0]       s_axis_tuser,
    // master side
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // out_red, out_green, out_blue
    output logic [flbcc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // register write port
    input  logic                                  i_cfg_we,
    input  logic [flbcc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [flbcc_pkg::COEF_W-1:0]          i_cfg_data
);

    logic                                     en;
    logic                                     in_vld;
    logic [flbcc_pkg::COL_W-1:0]              in_column;
    logic [flbcc_pkg::ROW_W-1:0]              in_row;
    flbcc_pkg::t_pix [flbcc_pkg::CH_NUM-1:0]  in_prev, in_next;
    flbcc_pkg::t_lut_wr                       in_lut_wr;

    logic [flbcc_pkg::COEF_W-1:0]             r_coef;
    logic                                     r_no_interp, r_no_dither;

    flbcc_pkg::t_ctl                          s3_ctl;
    flbcc_pkg::t_lut_wr                       s3_wr;
    flbcc_pkg::t_int [flbcc_pkg::CH_NUM-1:0]  s3_level;

    flbcc_pkg::t_ctl                          r_s4_ctl;
    flbcc_pkg::t_frac [flbcc_pkg::CH_NUM-1:0] r_s4_frac;
    flbcc_pkg::t_lut  [flbcc_pkg::CH_NUM-1:0] s4_lo, s4_hi;

    logic                                     pipe_vld;
    flbcc_pkg::t_int [flbcc_pkg::CH_NUM-1:0]  pipe_level;
    logic [flbcc_pkg::OUT_DATA_W-1:0]         pipe_data;

    logic                                     r_out_vld, r_skid_vld;
    logic [flbcc_pkg::OUT_DATA_W-1:0]         r_out_data, r_skid_data;

    // pipeline moves whenever the skid register is empty
    assign en            = !r_skid_vld;
    assign s_axis_tready = en;
    assign in_vld        = s_axis_tvalid && en;

    // unpack the slave beat
    assign in_column     = s_axis_tdata[6:0];
    assign in_row        = s_axis_tdata[13:7];
    assign in_prev[0]    = s_axis_tdata[21:14];
    assign in_prev[1]    = s_axis_tdata[29:22];
    assign in_prev[2]    = s_axis_tdata[37:30];
    assign in_next[0]    = s_axis_tdata[45:38];
    assign in_next[1]    = s_axis_tdata[53:46];
    assign in_next[2]    = s_axis_tdata[61:54];
    assign in_lut_wr.ch  = s_axis_tdata[63:62];
    assign in_lut_wr.idx = s_axis_tdata[72:64];
    assign in_lut_wr.val = s_axis_tdata[87:73];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef      <= flbcc_pkg::COEF_ONE;
            r_no_interp <= 1'b0;
            r_no_dither <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                flbcc_pkg::REG_COEF:      r_coef      <= i_cfg_data;
                flbcc_pkg::REG_NO_INTERP: r_no_interp <= i_cfg_data[0];
                flbcc_pkg::REG_NO_DITHER: r_no_dither <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // stages one to three: blend to 16-bit levels
    flbcc_blend u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_vld       (in_vld),
        .i_op        (s_axis_tuser[0]),
        .i_column    (in_column),
        .i_row       (in_row),
        .i_prev      (in_prev),
        .i_next      (in_next),
        .i_lut_wr    (in_lut_wr),
        .i_coef      (r_coef),
        .i_no_interp (r_no_interp),
        .o_ctl       (s3_ctl),
        .o_lut_wr    (s3_wr),
        .o_level     (s3_level)
    );

    // stage four: lut write and read of the two neighbor entries
    for (genvar k = 0; k < flbcc_pkg::CH_NUM; k++) begin : g_lut
        logic [flbcc_pkg::LUT_AW-1:0] raddr_lo;
        logic                         we;

        assign raddr_lo = {1'b0, s3_level[k][15:8]};
        assign we       = en && s3_ctl.wr && (int'(s3_wr.ch) == k);

        flbcc_lut_ram u_lut_ram (
            .i_clk      (i_clk),
            .i_en       (en),
            .i_we       (we),
            .i_waddr    (s3_wr.idx),
            .i_wdata    (s3_wr.val),
            .i_raddr_lo (raddr_lo),
            .i_raddr_hi (raddr_lo + 1'b1),
            .o_rdata_lo (s4_lo[k]),
            .o_rdata_hi (s4_hi[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_ctl <= '0;
        end else if (en) begin
            r_s4_ctl <= s3_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < flbcc_pkg::CH_NUM; k++) begin
                r_s4_frac[k] <= s3_level[k][7:0];
            end
        end
    end

    // stages five and six: interpolation and dither mode
    flbcc_interp u_interp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_ctl       (r_s4_ctl),
        .i_lo        (s4_lo),
        .i_hi        (s4_hi),
        .i_frac      (r_s4_frac),
        .i_no_dither (r_no_dither),
        .o_vld       (pipe_vld),
        .o_level     (pipe_level)
    );

    assign pipe_data = {pipe_level[2], pipe_level[1], pipe_level[0]};

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (m_axis_tready) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (!r_out_vld || m_axis_tready) begin
            r_out_vld <= pipe_vld;
        end else if (pipe_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (m_axis_tready) begin
                r_out_data <= r_skid_data;
            end
        end else if (!r_out_vld || m_axis_tready) begin
            r_out_data <= pipe_data;
        end else begin
            r_skid_data <= pipe_data;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

// File: rtl/flbcc_blend.sv
`timescale 1ns / 1ps

module flbcc_blend (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_en,
    input  logic                                      i_vld,
    input  logic                                      i_op,
    input  logic [flbcc_pkg::COL_W-1:0]               i_column,
    input  logic [flbcc_pkg::ROW_W-1:0]               i_row,
    input  flbcc_pkg::t_pix [flbcc_pkg::CH_NUM-1:0]   i_prev,
    input  flbcc_pkg::t_pix [flbcc_pkg::CH_NUM-1:0]   i_next,
    input  flbcc_pkg::t_lut_wr                        i_lut_wr,
    input  logic [flbcc_pkg::COEF_W-1:0]              i_coef,
    input  logic                                      i_no_interp,
    output flbcc_pkg::t_ctl                           o_ctl,
    output flbcc_pkg::t_lut_wr                        o_lut_wr,
    output flbcc_pkg::t_int [flbcc_pkg::CH_NUM-1:0]   o_level
);

    logic [flbcc_pkg::COEF_W-1:0] c_eff;
    logic [flbcc_pkg::WGT_W-1:0]  n_wp, n_wn;
    logic [flbcc_pkg::WGT_W-1:0]  r_wp, r_wn;
    flbcc_pkg::t_ctl              n_s1_ctl;

    flbcc_pkg::t_ctl                              r_s1_ctl;
    flbcc_pkg::t_lut_wr                           r_s1_wr;
    flbcc_pkg::t_pix [flbcc_pkg::CH_NUM-1:0]      r_s1_prev, r_s1_next;

    flbcc_pkg::t_ctl                              r_s2_ctl;
    flbcc_pkg::t_lut_wr                           r_s2_wr;
    logic [flbcc_pkg::PROD_W-1:0]                 r_s2_pp [flbcc_pkg::CH_NUM];
    logic [flbcc_pkg::PROD_W-1:0]                 r_s2_np [flbcc_pkg::CH_NUM];
    logic [flbcc_pkg::PROD_W:0]                   n_sum   [flbcc_pkg::CH_NUM];

    flbcc_pkg::t_ctl                              r_s3_ctl;
    flbcc_pkg::t_lut_wr                           r_s3_wr;
    flbcc_pkg::t_int [flbcc_pkg::CH_NUM-1:0]      r_s3_level;

    // effective coefficient: one in no-interpolation mode, else saturated to one
    always_comb begin
        priority if (i_no_interp) begin
            c_eff = flbcc_pkg::COEF_ONE;
        end else if (i_coef > flbcc_pkg::COEF_ONE) begin
            c_eff = flbcc_pkg::COEF_ONE;
        end else begin
            c_eff = i_coef;
        end
    end

    // blend weights; the user keeps them static while beats are in flight, the block does not enforce it
    assign n_wp = flbcc_pkg::WGT_W'(flbcc_pkg::COEF_ONE - c_eff)
                * flbcc_pkg::WGT_W'(flbcc_pkg::BLEND_SCALE);
    assign n_wn = flbcc_pkg::WGT_W'(c_eff) * flbcc_pkg::WGT_W'(flbcc_pkg::BLEND_SCALE);

    always_ff @(posedge i_clk) begin
        r_wp <= n_wp;
        r_wn <= n_wn;
    end

    // beat classification at entry
    always_comb begin
        n_s1_ctl.pix   = i_vld && (i_op == flbcc_pkg::OP_PIXEL)
                      && (int'(i_column) < flbcc_pkg::MAX_COLUMNS)
                      && (int'(i_row) < flbcc_pkg::MAX_ROWS);
        n_s1_ctl.wr    = i_vld && (i_op == flbcc_pkg::OP_LUT_WR)
                      && (int'(i_lut_wr.ch) < flbcc_pkg::CH_NUM)
                      && (int'(i_lut_wr.idx) < flbcc_pkg::LUT_ENTRIES);
        n_s1_ctl.first = (i_column == '0) && (i_row == '0);
    end

    // control of stages one to three
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
            r_s3_ctl <= '0;
        end else if (i_en) begin
            r_s1_ctl <= n_s1_ctl;
            r_s2_ctl <= r_s1_ctl;
            r_s3_ctl <= r_s2_ctl;
        end
    end

    // stage sums of the two products
    always_comb begin
        for (int k = 0; k < flbcc_pkg::CH_NUM; k++) begin
            n_sum[k] = {1'b0, r_s2_pp[k]} + {1'b0, r_s2_np[k]};
        end
    end

    // payload: capture, multiply, sum and scale
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_wr   <= i_lut_wr;
            r_s1_prev <= i_prev;
            r_s1_next <= i_next;
            r_s2_wr   <= r_s1_wr;
            r_s3_wr   <= r_s2_wr;
            for (int k = 0; k < flbcc_pkg::CH_NUM; k++) begin
                r_s2_pp[k]    <= flbcc_pkg::PROD_W'(r_s1_prev[k]) * flbcc_pkg::PROD_W'(r_wp);
                r_s2_np[k]    <= flbcc_pkg::PROD_W'(r_s1_next[k]) * flbcc_pkg::PROD_W'(r_wn);
                r_s3_level[k] <= n_sum[k][31:16];
            end
        end
    end

    assign o_ctl    = r_s3_ctl;
    assign o_lut_wr = r_s3_wr;
    assign o_level  = r_s3_level;

endmodule

// File: rtl/flbcc_lut_ram.sv
`timescale 1ns / 1ps

module flbcc_lut_ram (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic                          i_we,
    input  logic [flbcc_pkg::LUT_AW-1:0]  i_waddr,
    input  flbcc_pkg::t_lut               i_wdata,
    input  logic [flbcc_pkg::LUT_AW-1:0]  i_raddr_lo,
    input  logic [flbcc_pkg::LUT_AW-1:0]  i_raddr_hi,
    output flbcc_pkg::t_lut               o_rdata_lo,
    output flbcc_pkg::t_lut               o_rdata_hi
);

    flbcc_pkg::t_lut r_mem [flbcc_pkg::LUT_ENTRIES];
    flbcc_pkg::t_lut r_rdata_lo, r_rdata_hi;

    // one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_en) begin
            r_rdata_lo <= r_mem[i_raddr_lo];
            r_rdata_hi <= r_mem[i_raddr_hi];
        end
    end

    assign o_rdata_lo = r_rdata_lo;
    assign o_rdata_hi = r_rdata_hi;

endmodule

// File: rtl/flbcc_interp.sv
`timescale 1ns / 1ps

module flbcc_interp (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_en,
    input  flbcc_pkg::t_ctl                           i_ctl,
    input  flbcc_pkg::t_lut  [flbcc_pkg::CH_NUM-1:0]  i_lo,
    input  flbcc_pkg::t_lut  [flbcc_pkg::CH_NUM-1:0]  i_hi,
    input  flbcc_pkg::t_frac [flbcc_pkg::CH_NUM-1:0]  i_frac,
    input  logic                                      i_no_dither,
    output logic                                      o_vld,
    output flbcc_pkg::t_int  [flbcc_pkg::CH_NUM-1:0]  o_level
);

    flbcc_pkg::t_ctl                          r_s5_ctl;
    logic [flbcc_pkg::IP_PROD_W-1:0]          r_s5_lp [flbcc_pkg::CH_NUM];
    logic [flbcc_pkg::IP_PROD_W-1:0]          r_s5_hp [flbcc_pkg::CH_NUM];
    logic [flbcc_pkg::IP_PROD_W-1:0]          n_sum   [flbcc_pkg::CH_NUM];
    flbcc_pkg::t_int [flbcc_pkg::CH_NUM-1:0]  n_level;
    flbcc_pkg::t_int [flbcc_pkg::CH_NUM-1:0]  r_s6_level;
    logic                                     r_s6_vld;

    // valid of the two interpolation stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_ctl <= '0;
            r_s6_vld <= 1'b0;
        end else if (i_en) begin
            r_s5_ctl <= i_ctl;
            r_s6_vld <= r_s5_ctl.pix;
        end
    end

    // weighted sum, scaling and dither mode handling
    always_comb begin
        for (int k = 0; k < flbcc_pkg::CH_NUM; k++) begin
            n_sum[k]   = r_s5_lp[k] + r_s5_hp[k];
            n_level[k] = n_sum[k][22:7];
            if (i_no_dither) begin
                n_level[k] = n_level[k] & flbcc_pkg::DITHER_MASK;
                if (r_s5_ctl.first) begin
                    n_level[k] = flbcc_pkg::FIRST_PIXEL;
                end
            end
        end
    end

    // products of neighbor entries with their weights, then the result
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < flbcc_pkg::CH_NUM; k++) begin
                r_s5_lp[k] <= flbcc_pkg::IP_PROD_W'(i_lo[k])
                            * flbcc_pkg::IP_PROD_W'(flbcc_pkg::FRAC_ONE - {1'b0, i_frac[k]});
                r_s5_hp[k] <= flbcc_pkg::IP_PROD_W'(i_hi[k])
                            * flbcc_pkg::IP_PROD_W'(i_frac[k]);
            end
            r_s6_level <= n_level;
        end
    end

    assign o_vld   = r_s6_vld;
    assign o_level = r_s6_level;

endmodule
